FILE: rtl/lkrq_pkg.sv
package lkrq_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 32;
    localparam int DATA_BITS  = 64;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int COUNT_BITS = 5;

    typedef enum logic [2:0] {
        ACT_PUSH    = 3'd0,
        ACT_POP     = 3'd1,
        ACT_REFRESH = 3'd2,
        ACT_UPDATE  = 3'd3,
        ACT_REMOVE  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]           action;
        logic [KEY_BITS-1:0]  block_key;
        logic [DATA_BITS-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [1:0]            status;
        logic [KEY_BITS-1:0]   key_out;
        logic [DATA_BITS-1:0]  data_out;
        logic                  is_empty;
        logic [COUNT_BITS-1:0] entry_count;
    } t_rsp;

endpackage

FILE: rtl/lru_keyed_request_queue_core.sv
// Recency queue of up to DEPTH (key, payload) entries, oldest at the head. One transaction
// is taken at a time and o_in_ready stays low until its result has been loaded into the
// output register. A sequencer walks the entry store through a single read port: a push or
// an unused action code goes from acceptance directly to the done state; pop, refresh,
// update and remove scan from the head one entry a cycle and, on a match, then close the gap
// one entry a cycle. Loading the result waits while the previous result is still held in
// the output register. The result waits in the output register while the next transaction
// is accepted.
module lru_keyed_request_queue_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lkrq_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lkrq_pkg::t_rsp o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state                           r_state;
    logic [2:0]                       r_act;
    logic [lkrq_pkg::KEY_BITS-1:0]    r_key;
    logic [lkrq_pkg::DATA_BITS-1:0]   r_data;
    logic [lkrq_pkg::CNT_W-1:0]       r_idx;
    logic [lkrq_pkg::CNT_W-1:0]       r_occ;
    logic [lkrq_pkg::KEY_BITS-1:0]    r_fkey;
    logic [lkrq_pkg::DATA_BITS-1:0]   r_fdata;
    logic [1:0]                       r_status;
    logic [lkrq_pkg::KEY_BITS-1:0]    r_kout;
    logic [lkrq_pkg::DATA_BITS-1:0]   r_dout;
    lkrq_pkg::t_rsp                   r_out;
    logic                             r_out_valid;

    logic [lkrq_pkg::KEY_BITS-1:0]    r_keys [lkrq_pkg::DEPTH];
    logic [lkrq_pkg::DATA_BITS-1:0]   r_vals [lkrq_pkg::DEPTH];

    logic                             in_fire;
    logic                             out_load;
    logic [lkrq_pkg::CNT_W-1:0]       n_idx;
    logic [lkrq_pkg::CNT_W-1:0]       rd_ptr;
    logic [lkrq_pkg::KEY_BITS-1:0]    rd_key;
    logic [lkrq_pkg::DATA_BITS-1:0]   rd_data;
    logic                             wr_en;
    logic [lkrq_pkg::IDX_W-1:0]       wr_idx;
    logic [lkrq_pkg::KEY_BITS-1:0]    wr_key;
    logic [lkrq_pkg::DATA_BITS-1:0]   wr_data;
    logic                             more;
    logic [lkrq_pkg::CNT_W+lkrq_pkg::COUNT_BITS-1:0] count_ext;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE);
    assign n_idx      = lkrq_pkg::CNT_W'(r_idx + 1'b1);
    assign rd_ptr     = (r_state == S_SEARCH) ? r_idx : n_idx;
    assign rd_key     = r_keys[rd_ptr[lkrq_pkg::IDX_W-1:0]];
    assign rd_data    = r_vals[rd_ptr[lkrq_pkg::IDX_W-1:0]];
    assign more       = (n_idx < r_occ);
    assign count_ext  = {{lkrq_pkg::COUNT_BITS{1'b0}}, r_occ};

    // single write port into the entry store
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_idx[lkrq_pkg::IDX_W-1:0];
        wr_key  = rd_key;
        wr_data = rd_data;
        unique case (r_state)
            S_IDLE: begin
                wr_en   = in_fire && (i_in_data.action == lkrq_pkg::ACT_PUSH)
                          && (r_occ < lkrq_pkg::CNT_W'(lkrq_pkg::DEPTH));
                wr_idx  = r_occ[lkrq_pkg::IDX_W-1:0];
                wr_key  = i_in_data.block_key;
                wr_data = i_in_data.payload;
            end
            S_SHIFT: begin
                if (more) begin
                    wr_en = 1'b1;
                end else if (r_act == lkrq_pkg::ACT_REFRESH) begin
                    wr_en   = 1'b1;
                    wr_key  = r_key;
                    wr_data = r_fdata;
                end else if (r_act == lkrq_pkg::ACT_UPDATE) begin
                    wr_en   = 1'b1;
                    wr_key  = r_key;
                    wr_data = r_data;
                end
            end
            S_SEARCH, S_DONE: begin
                wr_en = 1'b0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_keys[wr_idx] <= wr_key;
            r_vals[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_act    <= i_in_data.action;
                        r_key    <= i_in_data.block_key;
                        r_data   <= i_in_data.payload;
                        r_idx    <= '0;
                        r_kout   <= '0;
                        r_dout   <= '0;
                        priority if (i_in_data.action == lkrq_pkg::ACT_PUSH) begin
                            if (r_occ < lkrq_pkg::CNT_W'(lkrq_pkg::DEPTH)) begin
                                r_occ    <= lkrq_pkg::CNT_W'(r_occ + 1'b1);
                                r_status <= lkrq_pkg::ST_DONE;
                            end else begin
                                r_status <= lkrq_pkg::ST_FULL;
                            end
                            r_state <= S_DONE;
                        end else if (i_in_data.action == lkrq_pkg::ACT_POP
                                     || i_in_data.action == lkrq_pkg::ACT_REFRESH
                                     || i_in_data.action == lkrq_pkg::ACT_UPDATE
                                     || i_in_data.action == lkrq_pkg::ACT_REMOVE) begin
                            r_status <= lkrq_pkg::ST_DONE;
                            r_state  <= S_SEARCH;
                        end else begin
                            r_status <= lkrq_pkg::ST_DONE;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_SEARCH: begin
                    priority if (r_idx >= r_occ) begin
                        r_status <= lkrq_pkg::ST_MISS;
                        r_state  <= S_DONE;
                    end else if (r_act == lkrq_pkg::ACT_POP || rd_key == r_key) begin
                        r_fkey  <= rd_key;
                        r_fdata <= rd_data;
                        r_state <= S_SHIFT;
                    end else begin
                        r_idx <= n_idx;
                    end
                end
                S_SHIFT: begin
                    if (more) begin
                        r_idx <= n_idx;
                    end else begin
                        if (r_act == lkrq_pkg::ACT_POP || r_act == lkrq_pkg::ACT_REFRESH) begin
                            r_kout <= r_fkey;
                            r_dout <= r_fdata;
                        end
                        if (r_act == lkrq_pkg::ACT_POP || r_act == lkrq_pkg::ACT_REMOVE) begin
                            r_occ <= lkrq_pkg::CNT_W'(r_occ - 1'b1);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out.status      <= r_status;
                        r_out.key_out     <= r_kout;
                        r_out.data_out    <= r_dout;
                        r_out.is_empty    <= (r_occ == '0);
                        r_out.entry_count <= count_ext[lkrq_pkg::COUNT_BITS-1:0];
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/lkrq_checker.sv
module lkrq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input lkrq_pkg::t_req i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input lkrq_pkg::t_rsp o_out_data
);

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a transaction is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == lkrq_pkg::ST_FULL)
        |-> (o_out_data.entry_count == lkrq_pkg::COUNT_BITS'(lkrq_pkg::DEPTH)))
        else $error("full status with queue not full");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != lkrq_pkg::ST_DONE)
        |-> (o_out_data.key_out == '0 && o_out_data.data_out == '0))
        else $error("failed action returned an entry");

endmodule

bind lru_keyed_request_queue_core lkrq_checker u_lkrq_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam logic [2:0]  ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  ACT_SPARE_LAST  = 3'd7;
    localparam int unsigned N_RANDOM        = 500;
    localparam int unsigned KEY_POOL        = 8;
    localparam int unsigned HOLD_AT         = 180;
    localparam int unsigned RX_HOLD_CYCLES  = 400;
    localparam int unsigned TAIL_CYCLES     = 40;
    localparam int unsigned REPORT_LIMIT    = 10;

    typedef enum int unsigned {
        RX_FREE,
        RX_COIN,
        RX_SPARSE
    } t_rx_pattern;

    class recency_tracker;
        logic [lkrq_pkg::KEY_BITS-1:0]  entry_key  [lkrq_pkg::DEPTH];
        logic [lkrq_pkg::DATA_BITS-1:0] entry_word [lkrq_pkg::DEPTH];
        int unsigned                    held;
        lkrq_pkg::t_rsp                 expected_q [$];
        int unsigned                    fail_count;

        function new();
            held       = 0;
            fail_count = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void drop_slot(int unsigned pos);
            for (int unsigned i = pos; i + 1 < held; i++) begin
                entry_key[i]  = entry_key[i + 1];
                entry_word[i] = entry_word[i + 1];
            end
            held--;
        endfunction

        function void append_slot(logic [lkrq_pkg::KEY_BITS-1:0] key,
                                  logic [lkrq_pkg::DATA_BITS-1:0] word);
            entry_key[held]  = key;
            entry_word[held] = word;
            held++;
        endfunction

        function lkrq_pkg::t_rsp apply_action(lkrq_pkg::t_req req);
            lkrq_pkg::t_rsp                 rsp;
            int                             pos;
            logic [lkrq_pkg::DATA_BITS-1:0] old_word;
            rsp        = '0;
            rsp.status = lkrq_pkg::ST_DONE;
            case (req.action)
                lkrq_pkg::ACT_PUSH: begin
                    if (held >= lkrq_pkg::DEPTH) rsp.status = lkrq_pkg::ST_FULL;
                    else append_slot(req.block_key, req.payload);
                end
                lkrq_pkg::ACT_POP: begin
                    if (held == 0) begin
                        rsp.status = lkrq_pkg::ST_MISS;
                    end else begin
                        rsp.key_out  = entry_key[0];
                        rsp.data_out = entry_word[0];
                        drop_slot(0);
                    end
                end
                lkrq_pkg::ACT_REFRESH, lkrq_pkg::ACT_UPDATE, lkrq_pkg::ACT_REMOVE: begin
                    pos = -1;
                    for (int i = held - 1; i >= 0; i--)
                        if (entry_key[i] == req.block_key) pos = i;
                    if (pos < 0) begin
                        rsp.status = lkrq_pkg::ST_MISS;
                    end else begin
                        old_word = entry_word[pos];
                        drop_slot(pos);
                        if (req.action == lkrq_pkg::ACT_REFRESH) begin
                            append_slot(req.block_key, old_word);
                            rsp.key_out  = req.block_key;
                            rsp.data_out = old_word;
                        end else if (req.action == lkrq_pkg::ACT_UPDATE) begin
                            append_slot(req.block_key, req.payload);
                        end
                    end
                end
                default: ;
            endcase
            rsp.is_empty    = (held == 0);
            rsp.entry_count = lkrq_pkg::COUNT_BITS'(held);
            return rsp;
        endfunction

        function void note_request(lkrq_pkg::t_req req);
            expected_q.push_back(apply_action(req));
        endfunction

        function void check_response(lkrq_pkg::t_rsp got);
            lkrq_pkg::t_rsp exp;
            bit             bad;
            if (expected_q.size() == 0) begin
                if (fail_count < REPORT_LIMIT)
                    $display("unexpected result: status %0d key %h data %h empty %0d count %0d",
                             got.status, got.key_out, got.data_out, got.is_empty,
                             got.entry_count);
                fail_count++;
                return;
            end
            exp = expected_q.pop_front();
            bad = (got.status !== exp.status) || (got.key_out !== exp.key_out)
                || (got.data_out !== exp.data_out) || (got.is_empty !== exp.is_empty)
                || (got.entry_count !== exp.entry_count);
            if (bad) begin
                if (fail_count < REPORT_LIMIT) begin
                    $display("mismatch: expected status %0d key %h data %h empty %0d count %0d",
                             exp.status, exp.key_out, exp.data_out, exp.is_empty,
                             exp.entry_count);
                    $display("          actual   status %0d key %h data %h empty %0d count %0d",
                             got.status, got.key_out, got.data_out, got.is_empty,
                             got.entry_count);
                end
                fail_count++;
            end
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           i_out_ready = 1'b0;
    lkrq_pkg::t_req i_in_data   = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    lkrq_pkg::t_rsp o_out_data;

    recency_tracker                tracker = new();
    bit                            rx_hold_req = 1'b0;
    logic [lkrq_pkg::KEY_BITS-1:0] key_pool [KEY_POOL];

    lru_keyed_request_queue_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(1_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_response(o_out_data);
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : rx_side
        int unsigned run_left;
        t_rx_pattern rx_mode;
        run_left = 0;
        rx_mode  = RX_FREE;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            if (run_left == 0) begin
                rx_mode  = t_rx_pattern'($urandom_range(0, 2));
                run_left = $urandom_range(10, 60);
            end
            run_left--;
            case (rx_mode)
                RX_FREE:   i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                default:   i_out_ready <= (run_left % 5 == 0);
            endcase
        end
    end

    task automatic send_item(input lkrq_pkg::t_req req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_request(req);
    endtask

    task automatic send_fields(input logic [2:0] action,
                               input logic [lkrq_pkg::KEY_BITS-1:0] key,
                               input logic [lkrq_pkg::DATA_BITS-1:0] word);
        lkrq_pkg::t_req req;
        req.action    = action;
        req.block_key = key;
        req.payload   = word;
        send_item(req);
    endtask

    task automatic idle_cycles(input int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    function automatic lkrq_pkg::t_req make_random_req(input bit fill_phase);
        lkrq_pkg::t_req req;
        int unsigned    pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            req.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        else if (fill_phase)
            req.action = (pick < 50) ? lkrq_pkg::ACT_PUSH :
                         (pick < 62) ? lkrq_pkg::ACT_POP :
                         (pick < 78) ? lkrq_pkg::ACT_REFRESH :
                         (pick < 90) ? lkrq_pkg::ACT_UPDATE : lkrq_pkg::ACT_REMOVE;
        else
            req.action = (pick < 24) ? lkrq_pkg::ACT_PUSH :
                         (pick < 50) ? lkrq_pkg::ACT_POP :
                         (pick < 70) ? lkrq_pkg::ACT_REFRESH :
                         (pick < 85) ? lkrq_pkg::ACT_UPDATE : lkrq_pkg::ACT_REMOVE;
        if ($urandom_range(0, 4) == 0) req.block_key = $urandom;
        else req.block_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        req.payload = {$urandom, $urandom};
        return req;
    endfunction

    initial begin : stimulus
        lkrq_pkg::t_req req;
        int unsigned    sent;
        int unsigned    burst_left;
        int unsigned    phase_left;
        bit             fill_phase;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue
        send_fields(lkrq_pkg::ACT_POP,     '1, '1);
        send_fields(lkrq_pkg::ACT_REFRESH, '0, '0);
        send_fields(lkrq_pkg::ACT_UPDATE,  '1, '1);
        send_fields(lkrq_pkg::ACT_REMOVE,  '0, '0);
        // fill to the brim, with a duplicate key
        send_fields(lkrq_pkg::ACT_PUSH, '0, '0);
        send_fields(lkrq_pkg::ACT_PUSH, '1, '1);
        send_fields(lkrq_pkg::ACT_PUSH, '0, 64'h5555_5555_5555_5555);
        for (int i = 3; i < lkrq_pkg::DEPTH; i++)
            send_fields(lkrq_pkg::ACT_PUSH, key_pool[2 + i % (KEY_POOL - 2)],
                        {$urandom, $urandom});
        send_fields(lkrq_pkg::ACT_PUSH, 32'h0bad_cafe, '1);
        send_fields(lkrq_pkg::ACT_REFRESH, '0, '1);
        send_fields(lkrq_pkg::ACT_UPDATE,  '1, 64'haaaa_aaaa_aaaa_aaaa);
        send_fields(lkrq_pkg::ACT_REMOVE,  '0, '0);
        send_fields(lkrq_pkg::ACT_REFRESH, 32'h1357_9bdf, '0);
        send_fields(lkrq_pkg::ACT_REMOVE,  32'h2468_ace0, '1);
        send_fields(ACT_SPARE_LAST, '1, '1);
        send_fields(lkrq_pkg::ACT_POP, '0, '0);
        wait_drained();

        sent       = 0;
        burst_left = 0;
        phase_left = 0;
        fill_phase = 1'b1;
        while (sent < N_RANDOM) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 7) == 0) wait_drained();
                else idle_cycles($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
            if (phase_left == 0) begin
                fill_phase = ~fill_phase;
                phase_left = $urandom_range(10, 40);
                key_pool[$urandom_range(2, KEY_POOL - 1)] = $urandom;
            end
            if (sent == HOLD_AT) rx_hold_req = 1'b1;
            req = make_random_req(fill_phase);
            send_item(req);
            if (req.action < ACT_SPARE_FIRST) sent++;
            burst_left--;
            phase_left--;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
